// File: hdl/matrix_power_mod_2x2_macros.svh
// ---------------------------------------------------------------------------
// matrix_power_mod_2x2 assertion macros
// shared assertion forms for the block's checker
// ---------------------------------------------------------------------------
`ifndef MATRIX_POWER_MOD_2X2_MACROS_SVH
`define MATRIX_POWER_MOD_2X2_MACROS_SVH

// assertion sampled on the rising clock, off during reset
`define MPM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// assertion that is also checked while reset is active
`define MPM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/mpm_pkg.sv
// ---------------------------------------------------------------------------
// mpm_pkg
// types and constants of the 2x2 modular matrix power block
// ---------------------------------------------------------------------------
package mpm_pkg;

	localparam int DATA_W       = 31;
	localparam int EXP_BITS_DEF = 32;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 32;

	localparam logic [DATA_W-1:0] MODULUS_RESET = 31'd1000000007;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_00 = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_01 = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_10 = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_11 = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 8'd4;

	typedef struct packed {
		logic [DATA_W-1:0] e00;
		logic [DATA_W-1:0] e01;
		logic [DATA_W-1:0] e10;
		logic [DATA_W-1:0] e11;
	} mat_t;

	// request to the modular multiplier
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] m;
	} mul_req_t;

	function automatic logic [DATA_W-1:0] mat_pick(input mat_t x, input logic [1:0] idx);
		logic [DATA_W-1:0] v;
		case (idx)
			2'd0: v = x.e00;
			2'd1: v = x.e01;
			2'd2: v = x.e10;
			2'd3: v = x.e11;
			default: v = x.e00;
		endcase
		return v;
	endfunction

	function automatic mat_t mat_put(input mat_t x, input logic [1:0] idx,
			input logic [DATA_W-1:0] v);
		mat_t y;
		y = x;
		case (idx)
			2'd0: y.e00 = v;
			2'd1: y.e01 = v;
			2'd2: y.e10 = v;
			2'd3: y.e11 = v;
			default: y.e00 = v;
		endcase
		return y;
	endfunction

endpackage

// File: hdl/mpm_modmul.sv
// ---------------------------------------------------------------------------
// mpm_modmul
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
// ---------------------------------------------------------------------------
module mpm_modmul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mpm_pkg::mul_req_t         req,
	output logic                      done,
	output logic [mpm_pkg::DATA_W-1:0] prod
);
	import mpm_pkg::*;

	localparam int CNT_W = $clog2(DATA_W + 1);

	logic [DATA_W-1:0] a_q, b_q, m_q, r_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;

	logic [DATA_W:0] dbl, dbl_red, sum, sum_red;
	logic [DATA_W-1:0] r_nxt;

	// r = 2r + bit*a mod m, operands below m
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		sum     = dbl_red + {1'b0, a_q};
		sum_red = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
		r_nxt   = b_q[DATA_W-1] ? sum_red[DATA_W-1:0] : dbl_red[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			m_q <= req.m;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= r_nxt;
			b_q <= {b_q[DATA_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = r_q;

endmodule

// File: hdl/matrix_power_mod_2x2.sv
// sequence: the base is reduced first, then one squaring per exponent bit up to the highest set bit,
// plus one multiply into the result for each set bit; a zero exponent needs only the reduction
// one transaction at a time, all products made by the single bit-serial multiplier
// a modulus below two gives an all-zero result
// reset: asynchronous, clears control and loads the register reset values
// ---------------------------------------------------------------------------
// matrix_power_mod_2x2
// 2x2 matrix power modulo m by binary square-and-multiply
// ---------------------------------------------------------------------------
module matrix_power_mod_2x2 #(
	parameter int EXP_BITS = mpm_pkg::EXP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mpm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [EXP_BITS-1:0]           exponent,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mpm_pkg::DATA_W-1:0]     result_00,
	output logic [mpm_pkg::DATA_W-1:0]     result_01,
	output logic [mpm_pkg::DATA_W-1:0]     result_10,
	output logic [mpm_pkg::DATA_W-1:0]     result_11
);
	import mpm_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_BASE   = 7'b0000010,
		ST_NEXT   = 7'b0000100,
		ST_MUL    = 7'b0001000,
		ST_ADD    = 7'b0010000,
		ST_COMMIT = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

	state_t state_q;

	logic [DATA_W-1:0] base00_q, base01_q, base10_q, base11_q, mod_q;
	mat_t acc_q, sq_q, tmp_q;
	logic [DATA_W-1:0] p1_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [1:0] elem_q;
	logic term_q, acc_ph_q, start_q;

	mul_req_t mul_req;
	logic mul_done;
	logic [DATA_W-1:0] mul_prod;
	logic [DATA_W-1:0] base_sel, opx, opy;
	logic [DATA_W:0] add_sum, add_red;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base00_q <= '0;
			base01_q <= '0;
			base10_q <= '0;
			base11_q <= '0;
			mod_q    <= MODULUS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENTRY_00: base00_q <= cfg_data[DATA_W-1:0];
				REG_ENTRY_01: base01_q <= cfg_data[DATA_W-1:0];
				REG_ENTRY_10: base10_q <= cfg_data[DATA_W-1:0];
				REG_ENTRY_11: base11_q <= cfg_data[DATA_W-1:0];
				REG_MODULUS:  mod_q    <= cfg_data[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (elem_q)
			2'd0: base_sel = base00_q;
			2'd1: base_sel = base01_q;
			2'd2: base_sel = base10_q;
			2'd3: base_sel = base11_q;
			default: base_sel = base00_q;
		endcase
		// element (i,j), term t: x[i][t] * sq[t][j]
		opx = mat_pick(acc_ph_q ? acc_q : sq_q, {elem_q[1], term_q});
		opy = mat_pick(sq_q, {term_q, elem_q[0]});
		mul_req.start = start_q;
		mul_req.m     = mod_q;
		if (state_q == ST_BASE) begin
			// base entry mod m as 1 * entry
			mul_req.a = DATA_W'(1);
			mul_req.b = base_sel;
		end else begin
			mul_req.a = opx;
			mul_req.b = opy;
		end
		add_sum = {1'b0, p1_q} + {1'b0, mul_prod};
		add_red = (add_sum >= {1'b0, mod_q}) ? add_sum - {1'b0, mod_q} : add_sum;
	end

	mpm_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			start_q  <= 1'b0;
			elem_q   <= '0;
			term_q   <= 1'b0;
			acc_ph_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						elem_q <= '0;
						if (mod_q < DATA_W'(2)) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_BASE;
							start_q <= 1'b1;
						end
					end
				end
				ST_BASE: begin
					if (mul_done) begin
						if (elem_q == 2'd3) begin
							state_q <= ST_NEXT;
						end else begin
							elem_q  <= elem_q + 2'd1;
							start_q <= 1'b1;
						end
					end
				end
				ST_NEXT: begin
					elem_q <= '0;
					term_q <= 1'b0;
					if (exp_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						acc_ph_q <= exp_q[0];
						state_q  <= ST_MUL;
						start_q  <= 1'b1;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						if (!term_q) begin
							term_q  <= 1'b1;
							start_q <= 1'b1;
						end else begin
							state_q <= ST_ADD;
						end
					end
				end
				ST_ADD: begin
					term_q <= 1'b0;
					if (elem_q == 2'd3) begin
						state_q <= ST_COMMIT;
					end else begin
						elem_q  <= elem_q + 2'd1;
						state_q <= ST_MUL;
						start_q <= 1'b1;
					end
				end
				ST_COMMIT: begin
					elem_q <= '0;
					if (acc_ph_q) begin
						// squaring still due for this bit
						acc_ph_q <= 1'b0;
						state_q  <= ST_MUL;
						start_q  <= 1'b1;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_OUT: begin
					if (out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				exp_q <= exponent;
				if (mod_q < DATA_W'(2))
					acc_q <= '0;
				else
					acc_q <= '{e00: DATA_W'(1), e01: '0, e10: '0, e11: DATA_W'(1)};
			end
			ST_BASE: begin
				if (mul_done)
					sq_q <= mat_put(sq_q, elem_q, mul_prod);
			end
			ST_MUL: begin
				if (mul_done && !term_q)
					p1_q <= mul_prod;
			end
			ST_ADD: tmp_q <= mat_put(tmp_q, elem_q, add_red[DATA_W-1:0]);
			ST_COMMIT: begin
				if (acc_ph_q) begin
					acc_q <= tmp_q;
				end else begin
					sq_q  <= tmp_q;
					exp_q <= exp_q >> 1;
				end
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign result_00 = acc_q.e00;
	assign result_01 = acc_q.e01;
	assign result_10 = acc_q.e10;
	assign result_11 = acc_q.e11;

endmodule

// File: hdl/mpm_checker.sv
// ---------------------------------------------------------------------------
// mpm_checker
// port-level checks of the matrix power block, bound to the top level
// ---------------------------------------------------------------------------
`include "matrix_power_mod_2x2_macros.svh"

module mpm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [mpm_pkg::DATA_W-1:0]     result_00
);
	import mpm_pkg::*;

	// one transaction in flight at a time
	`MPM_ASSERT(a_no_overlap, (out_valid |-> !in_ready), "input open while result pending")
	`MPM_ASSERT(a_busy_after_in, (in_valid && in_ready |=> !in_ready), "input taken twice")
	`MPM_ASSERT(a_idle_after_out, (out_valid && out_ready |=> in_ready && !out_valid),
		"block not idle after result transaction")
	`MPM_ASSERT(a_result_hold, (out_valid && !out_ready |=> out_valid && $stable(result_00)),
		"stalled result changed")

endmodule

bind matrix_power_mod_2x2 mpm_checker u_mpm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.result_00 (result_00)
);

// File: dv/tb_matrix_power_mod_2x2.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_matrix_power_mod_2x2
// self-checking bench: a directed table, then random exponents over several
// base and modulus settings, each result checked against a table value or a local matrix power
// ---------------------------------------------------------------------------
module tb_matrix_power_mod_2x2;
	import mpm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd9;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'd255;
	localparam int PHASES     = 6;
	localparam int PHASE_ITEMS = 44;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
	typedef struct {
		row_kind_t         kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [31:0]       data;
		logic [31:0]       ex;
		bit                typed;
		mat_t              want;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [31:0]           exponent;
	logic                  out_valid;
	logic                  out_ready;
	logic [DATA_W-1:0]     result_00;
	logic [DATA_W-1:0]     result_01;
	logic [DATA_W-1:0]     result_10;
	logic [DATA_W-1:0]     result_11;

	// local copy of the register file
	logic [DATA_W-1:0] base_m [4];
	logic [DATA_W-1:0] mod_m;

	mat_t pending_pow [$];
	int   errors;
	bit   no_idle;
	bit   hold_req;

	matrix_power_mod_2x2 dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .exponent(exponent),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_00(result_00), .result_01(result_01),
		.result_10(result_10), .result_11(result_11)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic mat_t mat_mulmod(input mat_t x, input mat_t y, input longint unsigned m);
		longint unsigned a00, a01, a10, a11, b00, b01, b10, b11;
		mat_t r;
		a00 = x.e00; a01 = x.e01; a10 = x.e10; a11 = x.e11;
		b00 = y.e00; b01 = y.e01; b10 = y.e10; b11 = y.e11;
		r.e00 = DATA_W'(((a00 * b00) % m + (a01 * b10) % m) % m);
		r.e01 = DATA_W'(((a00 * b01) % m + (a01 * b11) % m) % m);
		r.e10 = DATA_W'(((a10 * b00) % m + (a11 * b10) % m) % m);
		r.e11 = DATA_W'(((a10 * b01) % m + (a11 * b11) % m) % m);
		return r;
	endfunction

	function automatic mat_t power_mod(input logic [31:0] ex);
		longint unsigned m;
		mat_t acc, sq;
		m = mod_m;
		if (m < 2) begin
			acc = '0;
			return acc;
		end
		acc.e00 = DATA_W'(1 % m); acc.e01 = '0; acc.e10 = '0; acc.e11 = DATA_W'(1 % m);
		sq.e00 = DATA_W'(base_m[0] % m);
		sq.e01 = DATA_W'(base_m[1] % m);
		sq.e10 = DATA_W'(base_m[2] % m);
		sq.e11 = DATA_W'(base_m[3] % m);
		for (int i = 0; i < 32; i++) begin
			if (ex[i])
				acc = mat_mulmod(acc, sq, m);
			sq = mat_mulmod(sq, sq, m);
		end
		return acc;
	endfunction

	// register writes only once the block has drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		wait (pending_pow.size() == 0);
		repeat (20) @(negedge clk);
		cfg_index = idx;
		cfg_data  = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ENTRY_00: base_m[0] = data[DATA_W-1:0];
			REG_ENTRY_01: base_m[1] = data[DATA_W-1:0];
			REG_ENTRY_10: base_m[2] = data[DATA_W-1:0];
			REG_ENTRY_11: base_m[3] = data[DATA_W-1:0];
			REG_MODULUS:  mod_m     = data[DATA_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_exp(input logic [31:0] ex, input bit typed, input mat_t want);
		mat_t e;
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		e = typed ? want : power_mod(ex);
		exponent = ex;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_pow.push_back(e);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic [31:0] pick_entry();
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFFE | {1'($urandom_range(0, 1)), 31'd0};
			1: return $urandom_range(0, 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_modulus();
		case ($urandom_range(0, 7))
			0: return 32'd2;
			1: return 32'h7FFF_FFFF;
			2: return {1'($urandom_range(0, 1)), 30'd0, 1'($urandom_range(0, 1))};
			3: return $urandom_range(2, 100);
			default: return {1'($urandom_range(0, 1)), 31'd0} |
				32'($urandom_range(2, 32'h7FFF_FFFF));
		endcase
	endfunction

	function automatic logic [31:0] pick_exp();
		int r;
		r = $urandom_range(0, 99);
		if (r < 84)
			return $urandom_range(0, 31);
		else if (r < 94)
			return $urandom;
		else if (r < 97)
			return 32'hFFFF_FFFF;
		else
			return 32'h8000_0000;
	endfunction

	// receiver: random stalls, and one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (3000) @(negedge clk);
				hold_req = 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		mat_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pow.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h %h %h %h",
						result_00, result_01, result_10, result_11);
			end else begin
				e = pending_pow.pop_front();
				if (result_00 !== e.e00 || result_01 !== e.e01 ||
						result_10 !== e.e10 || result_11 !== e.e11) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %h %h %h %h actual %h %h %h %h",
							e.e00, e.e01, e.e10, e.e11,
							result_00, result_01, result_10, result_11);
				end
			end
		end
	end

	initial begin
		#150_000_000;
		$display("tb_matrix_power_mod_2x2: errors");
		$finish;
	end

	initial begin
		row_t rows [$];
		mat_t none;
		none = '0;
		rows = '{
			// reset setting: zero base, default modulus
			'{ROW_ITEM, 8'd0, 32'd0, 32'd0, 1'b1, '{31'd1, 31'd0, 31'd0, 31'd1}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'd1, 1'b1, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_CFG, REG_ENTRY_00, 32'd1, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_CFG, REG_ENTRY_01, 32'd1, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_CFG, REG_ENTRY_10, 32'd1, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'd10, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'd0, 1'b1, '{31'd1, 31'd0, 31'd0, 31'd1}},
			// modulus one and zero give all zeros
			'{ROW_CFG, REG_MODULUS, 32'd1, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'd5, 1'b1, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'd0, 1'b1, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_CFG, REG_MODULUS, 32'h8000_0000, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'd7, 1'b1, '{31'd0, 31'd0, 31'd0, 31'd0}},
			// largest modulus and entries, bit 31 of the data dropped
			'{ROW_CFG, REG_MODULUS, 32'h7FFF_FFFF, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_CFG, REG_ENTRY_00, 32'hFFFF_FFFE, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_CFG, REG_ENTRY_01, 32'hFFFF_FFFE, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_CFG, REG_ENTRY_10, 32'h7FFF_FFFE, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_CFG, REG_ENTRY_11, 32'hFFFF_FFFE, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'd1, 1'b1,
				'{31'h7FFF_FFFE, 31'h7FFF_FFFE, 31'h7FFF_FFFE, 31'h7FFF_FFFE}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'h8000_0000, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_CFG, REG_MODULUS, 32'd2, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'd0, 1'b1, '{31'd1, 31'd0, 31'd0, 31'd1}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'd3, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			// entries above the modulus are reduced first
			'{ROW_CFG, REG_MODULUS, 32'd5, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_CFG, REG_ENTRY_00, 32'd7, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_CFG, REG_ENTRY_01, 32'd12, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_CFG, REG_ENTRY_10, 32'd100, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_CFG, REG_ENTRY_11, 32'd5, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'd1, 1'b1, '{31'd2, 31'd2, 31'd0, 31'd0}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'd2, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			// writes past the register list change nothing
			'{ROW_CFG, REG_UNUSED_LO, 32'd3, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_CFG, REG_UNUSED_HI, 32'hFFFF_FFFF, 32'd0, 1'b0, '{31'd0, 31'd0, 31'd0, 31'd0}},
			'{ROW_ITEM, 8'd0, 32'd0, 32'd1, 1'b1, '{31'd2, 31'd2, 31'd0, 31'd0}}
		};

		errors    = 0;
		no_idle   = 1'b0;
		hold_req  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		exponent  = '0;
		base_m    = '{default: '0};
		mod_m     = MODULUS_RESET;
		arst_n    = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG)
				write_reg(rows[i].idx, rows[i].data);
			else
				send_exp(rows[i].ex, rows[i].typed, rows[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1)
				no_idle = 1'b1;
			write_reg(REG_ENTRY_00, pick_entry());
			write_reg(REG_ENTRY_01, pick_entry());
			write_reg(REG_ENTRY_10, pick_entry());
			write_reg(REG_ENTRY_11, pick_entry());
			write_reg(REG_MODULUS, pick_modulus());
			if ($urandom_range(0, 1) == 0)
				write_reg(8'($urandom_range(5, 255)), $urandom);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// long receiver hold-off while short transactions keep coming
				if (p == 1 && k == 5)
					hold_req = 1'b1;
				if (p == 2 && k == 10) begin
					wait (pending_pow.size() == 0);
					@(negedge clk);
				end
				if (p == 1 && k >= 5 && k < 15)
					send_exp($urandom_range(0, 3), 1'b0, none);
				else
					send_exp(pick_exp(), 1'b0, none);
			end
		end

		wait (pending_pow.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_pow.size() == 0)
			$display("tb_matrix_power_mod_2x2: clean");
		else
			$display("tb_matrix_power_mod_2x2: errors");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/mpm_pkg.sv
hdl/mpm_modmul.sv
hdl/matrix_power_mod_2x2.sv
hdl/mpm_checker.sv
dv/tb_matrix_power_mod_2x2.sv
